// ===== sv/rtks_pkg.sv =====
// Shared types, command and status codes for the radix tree key store.
`default_nettype none
package rtks_pkg;

	// Fixed field widths of the request and response transactions.
	localparam int CMD_W    = 2;
	localparam int KEY_W    = 64;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 8;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OCCUPIED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUST  = 2'd3;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE,
		S_GROW,
		S_CHK_REQ,
		S_CHK_RSP,
		S_EVAL,
		S_ROOT_CLR,
		S_PUT_REQ,
		S_PUT_RSP,
		S_BR_CLR,
		S_LEAF_TAKE,
		S_LEAF_POP,
		S_LEAF_PLACE,
		S_FIND_REQ,
		S_FIND_RSP,
		S_FOUND,
		S_GET_RD,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== sv/rtks_if.sv =====
// Request and response channel interfaces of the radix tree key store.
`default_nettype none
interface rtks_req_if;
	logic                         valid;
	logic                         ready;
	logic [rtks_pkg::CMD_W-1:0]   cmd;
	logic [rtks_pkg::KEY_W-1:0]   key;
	logic [rtks_pkg::VAL_W-1:0]   value;

	modport source (output valid, output cmd, output key, output value, input ready);
	modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface rtks_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [rtks_pkg::STATUS_W-1:0]  status;
	logic [rtks_pkg::VAL_W-1:0]     found_value;
	logic [rtks_pkg::SLOT_W-1:0]    leaf_slot;

	modport source (output valid, output status, output found_value, output leaf_slot,
		input ready);
	modport sink   (input valid, input status, input found_value, input leaf_slot,
		output ready);
endinterface
`default_nettype wire

// ===== sv/rtks_key_unit.sv =====
// Key unit: capacity check by a shared shifter and digit selection for one level.
`default_nettype none
module rtks_key_unit #(
	parameter int RADIX_BITS = 4,
	parameter int MAXL       = 16,
	parameter int DW         = 5
) (
	input  wire logic [rtks_pkg::KEY_W-1:0] key,
	input  wire logic [DW-1:0]              fit_lvl,
	input  wire logic [DW-1:0]              dig_lvl,
	output logic                            fit,
	output logic [RADIX_BITS-1:0]           digit
);
	localparam int PW  = MAXL * RADIX_BITS;
	localparam int SHW = $clog2(PW + 1);

	logic [PW-1:0]  key_pad;
	logic [SHW-1:0] shamt;

	// A key fits a tree of fit_lvl levels when nothing remains above its digits.
	assign shamt   = SHW'(fit_lvl * RADIX_BITS);
	assign fit     = ((key >> shamt) == '0);
	assign key_pad = PW'(key);

	// Digit of the key at level dig_lvl, zero above the top level.
	always_comb begin
		digit = '0;
		if (int'(dig_lvl) < MAXL) begin
			digit = key_pad[int'(dig_lvl) * RADIX_BITS +: RADIX_BITS];
		end
	end

endmodule
`default_nettype wire

// ===== sv/radix_tree_key_store_core.sv =====
// Top level of the radix tree key store: sequencer, node, leaf and recycle memories.
`default_nettype none
// Keyed store over a radix tree that grows in depth, one transaction at a time.
// A request is taken only while the sequencer is idle; every request gives one
// response, which waits in an output register. Each tree level takes a node
// memory read and its registered result. A put first scans the key one level
// per cycle to find the needed depth, checks its path level by level, and then
// clears all 2^RADIX_BITS entries of each branch it takes from the pool. The
// node memory takes one write and one read per cycle. Memories need no clearing
// after reset: branches are cleared when taken.
module radix_tree_key_store_core #(
	parameter int RADIX_BITS   = 4,
	parameter int BRANCH_NODES = 256,
	parameter int LEAF_SLOTS   = 256,
	parameter int VALUE_BITS   = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rtks_req_if.sink   req,
	rtks_rsp_if.source rsp
);
	localparam int FANOUT  = 1 << RADIX_BITS;
	localparam int MAXL    = (64 + RADIX_BITS - 1) / RADIX_BITS;
	localparam int DW      = $clog2(MAXL + 1);
	localparam int BIW     = $clog2(BRANCH_NODES);
	localparam int LIW     = $clog2(LEAF_SLOTS);
	localparam int RW      = $clog2((BRANCH_NODES > LEAF_SLOTS ? BRANCH_NODES : LEAF_SLOTS) + 1);
	localparam int BCW     = $clog2(BRANCH_NODES + 1);
	localparam int LCW     = $clog2(LEAF_SLOTS + 1);
	localparam int AW      = BIW + RADIX_BITS;
	localparam int ENTRIES = BRANCH_NODES * FANOUT;
	localparam int VSW     = VALUE_BITS < rtks_pkg::VAL_W ? VALUE_BITS : rtks_pkg::VAL_W;
	localparam int BNW     = DW + 1;

	rtks_pkg::state_t state_q, state_d;

	// Tree bookkeeping.
	logic [DW-1:0]  depth_q;
	logic [RW-1:0]  root_q;
	logic [BCW-1:0] bnf_q;
	logic [LCW-1:0] lnf_q;
	logic [LCW-1:0] rcnt_q;

	// Transaction and walk registers.
	logic [rtks_pkg::CMD_W-1:0]    cmd_q;
	logic [rtks_pkg::KEY_W-1:0]    key_q;
	logic [rtks_pkg::VAL_W-1:0]    val_q;
	logic [DW-1:0]                 need_q;
	logic [DW-1:0]                 top_q;
	logic [BNW-1:0]                br_need_q;
	logic [DW-1:0]                 h_q;
	logic [RW-1:0]                 cur_q;
	logic [RW-1:0]                 leaf_q;
	logic [AW-1:0]                 hold_addr_q;
	logic                          hold_root_q;
	logic [BIW-1:0]                new_br_q;
	logic [RADIX_BITS-1:0]         clr_q;
	logic [rtks_pkg::STATUS_W-1:0] res_status_q;
	logic [LIW-1:0]                res_slot_q;
	logic [rtks_pkg::VAL_W-1:0]    res_found_q;

	// Output register.
	logic                          ovalid_q;
	logic [rtks_pkg::STATUS_W-1:0] ostatus_q;
	logic [rtks_pkg::VAL_W-1:0]    ofound_q;
	logic [rtks_pkg::SLOT_W-1:0]   oslot_q;

	// Memories.
	logic [RW-1:0]  node_mem [0:ENTRIES-1];
	logic [VSW-1:0] leaf_mem [0:LEAF_SLOTS-1];
	logic [LIW-1:0] stack_mem [0:LEAF_SLOTS-1];
	logic [RW-1:0]  node_rd_q;
	logic [VSW-1:0] leaf_rd_q;
	logic [LIW-1:0] stack_rd_q;

	logic           node_we;
	logic [AW-1:0]  node_waddr;
	logic [RW-1:0]  node_wdata;
	logic [AW-1:0]  node_raddr;

	// Shared key unit signals.
	logic [rtks_pkg::KEY_W-1:0] ku_key;
	logic [DW-1:0]              ku_fit_lvl;
	logic [DW-1:0]              ku_dig_lvl;
	logic                       ku_fit;
	logic [RADIX_BITS-1:0]      ku_digit;

	// Decisions shared by next-state and datapath logic.
	logic req_fire;
	logic load_out;
	logic child_null;
	logic h_last;
	logic clr_last;
	logic grow_more;
	logic exhaust;
	logic lookup_ok;
	logic is_put;

	assign req_fire   = req.valid && req.ready;
	assign load_out   = (state_q == rtks_pkg::S_DONE) && (!ovalid_q || rsp.ready);
	assign child_null = (node_rd_q == '0);
	assign h_last     = (h_q == DW'(1));
	assign clr_last   = &clr_q;
	assign grow_more  = (int'(need_q) < MAXL) && !ku_fit;
	assign exhaust    = (16'(br_need_q) > (16'(BRANCH_NODES) - 16'(bnf_q)))
		|| ((rcnt_q == '0) && (16'(lnf_q) >= 16'(LEAF_SLOTS)));
	assign is_put     = (req.cmd == rtks_pkg::CMD_PUT);
	assign lookup_ok  = ((req.cmd == rtks_pkg::CMD_GET) || (req.cmd == rtks_pkg::CMD_DEL))
		&& ku_fit;

	// The key unit sees the port while idle and the held key afterwards.
	assign ku_key     = (state_q == rtks_pkg::S_IDLE) ? req.key : key_q;
	assign ku_fit_lvl = (state_q == rtks_pkg::S_IDLE) ? depth_q : need_q;
	assign ku_dig_lvl = (state_q == rtks_pkg::S_GROW) ? need_q : (h_q - DW'(1));

	rtks_key_unit #(
		.RADIX_BITS (RADIX_BITS),
		.MAXL       (MAXL),
		.DW         (DW)
	) u_key (
		.key     (ku_key),
		.fit_lvl (ku_fit_lvl),
		.dig_lvl (ku_dig_lvl),
		.fit     (ku_fit),
		.digit   (ku_digit)
	);

	assign node_raddr = {BIW'(cur_q - RW'(1)), ku_digit};

	// Next state and node memory write port.
	always_comb begin
		state_d    = state_q;
		node_we    = 1'b0;
		node_waddr = {new_br_q, clr_q};
		node_wdata = '0;
		unique case (state_q)
			rtks_pkg::S_IDLE: begin
				if (req.valid) begin
					if (is_put) begin
						state_d = rtks_pkg::S_GROW;
					end else if (lookup_ok) begin
						state_d = (depth_q == '0) ? rtks_pkg::S_FOUND : rtks_pkg::S_FIND_REQ;
					end else begin
						state_d = rtks_pkg::S_DONE;
					end
				end
			end
			rtks_pkg::S_GROW: begin
				if (!grow_more) begin
					if (need_q > depth_q) begin
						state_d = rtks_pkg::S_EVAL;
					end else if (depth_q == '0) begin
						state_d = (root_q != '0) ? rtks_pkg::S_DONE : rtks_pkg::S_EVAL;
					end else begin
						state_d = rtks_pkg::S_CHK_REQ;
					end
				end
			end
			rtks_pkg::S_CHK_REQ: state_d = rtks_pkg::S_CHK_RSP;
			rtks_pkg::S_CHK_RSP: begin
				if (child_null) begin
					state_d = rtks_pkg::S_EVAL;
				end else if (h_last) begin
					state_d = rtks_pkg::S_DONE;
				end else begin
					state_d = rtks_pkg::S_CHK_REQ;
				end
			end
			rtks_pkg::S_EVAL: begin
				if (exhaust) begin
					state_d = rtks_pkg::S_DONE;
				end else if (depth_q < need_q) begin
					state_d = rtks_pkg::S_ROOT_CLR;
				end else if (depth_q == '0) begin
					state_d = rtks_pkg::S_LEAF_TAKE;
				end else begin
					state_d = rtks_pkg::S_PUT_REQ;
				end
			end
			rtks_pkg::S_ROOT_CLR: begin
				node_we    = 1'b1;
				node_wdata = (clr_q == '0) ? root_q : '0;
				if (clr_last && ((depth_q + DW'(1)) >= need_q)) begin
					state_d = rtks_pkg::S_PUT_REQ;
				end
			end
			rtks_pkg::S_PUT_REQ: state_d = rtks_pkg::S_PUT_RSP;
			rtks_pkg::S_PUT_RSP: begin
				if (child_null) begin
					if (h_last) begin
						state_d = rtks_pkg::S_LEAF_TAKE;
					end else begin
						node_we    = 1'b1;
						node_waddr = node_raddr;
						node_wdata = RW'(bnf_q) + RW'(1);
						state_d    = rtks_pkg::S_BR_CLR;
					end
				end else begin
					state_d = rtks_pkg::S_PUT_REQ;
				end
			end
			rtks_pkg::S_BR_CLR: begin
				node_we = 1'b1;
				if (clr_last) begin
					state_d = rtks_pkg::S_PUT_REQ;
				end
			end
			rtks_pkg::S_LEAF_TAKE: begin
				state_d = (rcnt_q != '0) ? rtks_pkg::S_LEAF_POP : rtks_pkg::S_LEAF_PLACE;
			end
			rtks_pkg::S_LEAF_POP: state_d = rtks_pkg::S_LEAF_PLACE;
			rtks_pkg::S_LEAF_PLACE: begin
				if (!hold_root_q) begin
					node_we    = 1'b1;
					node_waddr = hold_addr_q;
					node_wdata = leaf_q;
				end
				state_d = rtks_pkg::S_DONE;
			end
			rtks_pkg::S_FIND_REQ: state_d = rtks_pkg::S_FIND_RSP;
			rtks_pkg::S_FIND_RSP: begin
				if (child_null) begin
					state_d = rtks_pkg::S_DONE;
				end else if (h_last) begin
					state_d = rtks_pkg::S_FOUND;
				end else begin
					state_d = rtks_pkg::S_FIND_REQ;
				end
			end
			rtks_pkg::S_FOUND: begin
				if ((leaf_q != '0) && (cmd_q == rtks_pkg::CMD_GET)) begin
					state_d = rtks_pkg::S_GET_RD;
				end else begin
					if ((leaf_q != '0) && !hold_root_q) begin
						node_we    = 1'b1;
						node_waddr = hold_addr_q;
						node_wdata = '0;
					end
					state_d = rtks_pkg::S_DONE;
				end
			end
			rtks_pkg::S_GET_RD: state_d = rtks_pkg::S_DONE;
			rtks_pkg::S_DONE: begin
				if (load_out) begin
					state_d = rtks_pkg::S_IDLE;
				end
			end
			default: state_d = rtks_pkg::S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtks_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Node memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		node_rd_q <= node_mem[node_raddr];
	end

	// Leaf value memory: written when a put places its leaf, read for a get.
	always_ff @(posedge clk) begin
		if (state_q == rtks_pkg::S_LEAF_PLACE) begin
			leaf_mem[LIW'(leaf_q - RW'(1))] <= VSW'(val_q);
		end
		leaf_rd_q <= leaf_mem[LIW'(leaf_q - RW'(1))];
	end

	// Recycle stack: a delete pushes the freed slot, a put pops the last one.
	always_ff @(posedge clk) begin
		if ((state_q == rtks_pkg::S_FOUND) && (leaf_q != '0) && (cmd_q == rtks_pkg::CMD_DEL)
			&& (32'(rcnt_q) < LEAF_SLOTS)) begin
			stack_mem[LIW'(rcnt_q)] <= LIW'(leaf_q - RW'(1));
		end
		stack_rd_q <= stack_mem[LIW'(rcnt_q - LCW'(1))];
	end

	// Tree bookkeeping and output valid, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			root_q   <= '0;
			bnf_q    <= '0;
			lnf_q    <= '0;
			rcnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				rtks_pkg::S_EVAL: begin
					if (!exhaust && (depth_q < need_q)) begin
						bnf_q <= bnf_q + BCW'(1);
					end
				end
				rtks_pkg::S_ROOT_CLR: begin
					if (clr_last) begin
						root_q  <= RW'(new_br_q) + RW'(1);
						depth_q <= depth_q + DW'(1);
						if ((depth_q + DW'(1)) < need_q) begin
							bnf_q <= bnf_q + BCW'(1);
						end
					end
				end
				rtks_pkg::S_PUT_RSP: begin
					if (child_null && !h_last) begin
						bnf_q <= bnf_q + BCW'(1);
					end
				end
				rtks_pkg::S_LEAF_TAKE: begin
					if (rcnt_q != '0) begin
						rcnt_q <= rcnt_q - LCW'(1);
					end else begin
						lnf_q <= lnf_q + LCW'(1);
					end
				end
				rtks_pkg::S_LEAF_PLACE: begin
					if (hold_root_q) begin
						root_q <= leaf_q;
					end
				end
				rtks_pkg::S_FOUND: begin
					if ((leaf_q != '0) && (cmd_q == rtks_pkg::CMD_DEL)) begin
						if (32'(rcnt_q) < LEAF_SLOTS) begin
							rcnt_q <= rcnt_q + LCW'(1);
						end
						if (hold_root_q) begin
							root_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Transaction and walk registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			rtks_pkg::S_IDLE: begin
				if (req_fire) begin
					cmd_q        <= req.cmd;
					key_q        <= req.key;
					val_q        <= req.value;
					need_q       <= depth_q;
					top_q        <= depth_q;
					clr_q        <= '0;
					res_status_q <= rtks_pkg::ST_NOTFOUND;
					res_slot_q   <= '0;
					res_found_q  <= '0;
					leaf_q       <= root_q;
					hold_root_q  <= 1'b1;
					cur_q        <= root_q;
					h_q          <= depth_q;
				end
			end
			rtks_pkg::S_GROW: begin
				if (grow_more) begin
					if (ku_digit != '0) begin
						top_q <= need_q;
					end
					need_q <= need_q + DW'(1);
				end else begin
					br_need_q <= (need_q > depth_q)
						? (BNW'(need_q) - BNW'(depth_q) + BNW'(top_q)) : '0;
					cur_q <= root_q;
					h_q   <= depth_q;
					if ((need_q == depth_q) && (depth_q == '0) && (root_q != '0)) begin
						res_status_q <= rtks_pkg::ST_OCCUPIED;
					end
				end
			end
			rtks_pkg::S_CHK_RSP: begin
				if (child_null) begin
					br_need_q <= BNW'(h_q) - BNW'(1);
				end else if (h_last) begin
					res_status_q <= rtks_pkg::ST_OCCUPIED;
				end else begin
					cur_q <= node_rd_q;
					h_q   <= h_q - DW'(1);
				end
			end
			rtks_pkg::S_EVAL: begin
				if (exhaust) begin
					res_status_q <= rtks_pkg::ST_EXHAUST;
				end else begin
					new_br_q    <= BIW'(bnf_q);
					clr_q       <= '0;
					hold_root_q <= 1'b1;
					cur_q       <= root_q;
					h_q         <= depth_q;
				end
			end
			rtks_pkg::S_ROOT_CLR: begin
				clr_q <= clr_q + RADIX_BITS'(1);
				if (clr_last) begin
					if ((depth_q + DW'(1)) < need_q) begin
						new_br_q <= BIW'(bnf_q);
					end else begin
						cur_q <= RW'(new_br_q) + RW'(1);
						h_q   <= depth_q + DW'(1);
					end
				end
			end
			rtks_pkg::S_PUT_RSP: begin
				if (child_null) begin
					hold_addr_q <= node_raddr;
					hold_root_q <= 1'b0;
					new_br_q    <= BIW'(bnf_q);
				end else begin
					cur_q <= node_rd_q;
					h_q   <= h_q - DW'(1);
				end
			end
			rtks_pkg::S_BR_CLR: begin
				clr_q <= clr_q + RADIX_BITS'(1);
				if (clr_last) begin
					cur_q <= RW'(new_br_q) + RW'(1);
					h_q   <= h_q - DW'(1);
				end
			end
			rtks_pkg::S_LEAF_TAKE: begin
				if (rcnt_q == '0) begin
					leaf_q <= RW'(lnf_q) + RW'(1);
				end
			end
			rtks_pkg::S_LEAF_POP: begin
				leaf_q <= RW'(stack_rd_q) + RW'(1);
			end
			rtks_pkg::S_LEAF_PLACE: begin
				res_status_q <= rtks_pkg::ST_OK;
				res_slot_q   <= LIW'(leaf_q - RW'(1));
			end
			rtks_pkg::S_FIND_RSP: begin
				hold_addr_q <= node_raddr;
				hold_root_q <= 1'b0;
				cur_q       <= node_rd_q;
				leaf_q      <= node_rd_q;
				h_q         <= h_q - DW'(1);
			end
			rtks_pkg::S_FOUND: begin
				if (leaf_q != '0) begin
					res_status_q <= rtks_pkg::ST_OK;
					res_slot_q   <= LIW'(leaf_q - RW'(1));
				end
			end
			rtks_pkg::S_GET_RD: begin
				res_found_q <= rtks_pkg::VAL_W'(leaf_rd_q);
			end
			rtks_pkg::S_DONE: begin
				if (load_out) begin
					ostatus_q <= res_status_q;
					ofound_q  <= res_found_q;
					oslot_q   <= rtks_pkg::SLOT_W'(res_slot_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Channel outputs.
	assign req.ready       = (state_q == rtks_pkg::S_IDLE);
	assign rsp.valid       = ovalid_q;
	assign rsp.status      = ostatus_q;
	assign rsp.found_value = ofound_q;
	assign rsp.leaf_slot   = oslot_q;

`ifndef SYNTHESIS
	// The tree never grows past the number of levels that a 64-bit key needs.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(depth_q) <= MAXL)
		else $error("tree depth beyond the level limit");

	// The branch pool is never overdrawn.
	a_branch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(bnf_q) <= BRANCH_NODES)
		else $error("branch pool overdrawn");

	// Only leaves that were handed out can be waiting for reuse.
	a_recycle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= lnf_q)
		else $error("recycle stack holds more slots than were taken");

	// A tree with levels always has a root branch.
	a_root_present: assert property (@(posedge clk) disable iff (!arst_n)
		(depth_q != '0) |-> (root_q != '0))
		else $error("tree has levels but no root");

	// A response is loaded only as the sequencer returns to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (state_q == rtks_pkg::S_IDLE) && ovalid_q)
		else $error("response loaded without returning to idle");
`endif

endmodule
`default_nettype wire

// ===== bench/radix_tree_key_store_checker.sv =====
// Transaction checker for the radix tree key store: predicts every response and compares it.
`default_nettype none
module radix_tree_key_store_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	rtks_req_if       req,
	rtks_rsp_if       rsp,
	output int        failures,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIGIT_W   = 4;
	localparam int FANOUT    = 1 << DIGIT_W;
	localparam int BRANCHES  = 256;
	localparam int LEAVES    = 256;
	localparam int MAX_DEPTH = 16;

	typedef struct packed {
		logic [rtks_pkg::STATUS_W-1:0] status;
		logic [rtks_pkg::VAL_W-1:0]    found_value;
		logic [rtks_pkg::SLOT_W-1:0]   leaf_slot;
	} answer_t;

	// Shadow copy of the tree; references are slot index plus one, zero meaning empty.
	int          depth;
	int          root;
	int          children [BRANCHES*FANOUT];
	int          branch_fill;
	logic [31:0] leaf_data [LEAVES];
	int          leaf_fill;
	int          freed_slots [LEAVES];
	int          freed_count;

	answer_t     answers_due [$];

	// Largest key that a tree of d levels can hold.
	function automatic logic [63:0] capacity(int d);
		if (d * DIGIT_W >= 64)
			return '1;
		return (64'd1 << (d * DIGIT_W)) - 64'd1;
	endfunction

	function automatic int digit(logic [63:0] k, int lvl);
		if (lvl * DIGIT_W >= 64)
			return 0;
		return int'((k >> (lvl * DIGIT_W)) & 64'(FANOUT - 1));
	endfunction

	function automatic int child_index(int node, logic [63:0] k, int h);
		return ((node - 1) % BRANCHES) * FANOUT + digit(k, h - 1);
	endfunction

	function automatic int take_branch();
		int b;
		b = branch_fill % BRANCHES;
		branch_fill++;
		for (int i = 0; i < FANOUT; i++)
			children[b*FANOUT + i] = 0;
		return b + 1;
	endfunction

	// Freed slots are reused last in, first out before fresh ones are taken.
	function automatic int take_leaf();
		if (freed_count > 0) begin
			freed_count--;
			return freed_slots[freed_count % LEAVES] + 1;
		end
		leaf_fill++;
		return ((leaf_fill - 1) % LEAVES) + 1;
	endfunction

	// Insert: find the needed depth, check the path and the pools, then grow the root and allocate.
	function automatic logic [rtks_pkg::STATUS_W-1:0] insert(logic [63:0] k, logic [31:0] v,
		output int slot);
		int need;
		int branches_needed;
		int t;
		int cur;
		int c;
		int p;
		slot = 0;
		need = depth;
		branches_needed = 0;
		while (need < MAX_DEPTH && capacity(need) < k)
			need++;
		if (need > depth) begin
			t = depth;
			for (int h = depth; h < need; h++)
				if (digit(k, h) != 0)
					t = h;
			branches_needed = (need - depth) + t;
		end else if (depth == 0) begin
			if (root != 0)
				return rtks_pkg::ST_OCCUPIED;
		end else begin
			cur = root;
			for (int h = depth; h >= 1; h--) begin
				c = children[child_index(cur, k, h)];
				if (c == 0) begin
					branches_needed = h - 1;
					break;
				end
				if (h == 1)
					return rtks_pkg::ST_OCCUPIED;
				cur = c;
			end
		end
		if (branches_needed > BRANCHES - branch_fill)
			return rtks_pkg::ST_EXHAUST;
		if (freed_count == 0 && leaf_fill >= LEAVES)
			return rtks_pkg::ST_EXHAUST;
		while (depth < need) begin
			c = take_branch();
			children[(c - 1) * FANOUT] = root;
			root = c;
			depth++;
		end
		if (depth == 0) begin
			root = take_leaf();
			cur = root;
		end else begin
			cur = root;
			for (int h = depth; h >= 1; h--) begin
				p = child_index(cur, k, h);
				if (children[p] == 0)
					children[p] = (h == 1) ? take_leaf() : take_branch();
				cur = children[p];
			end
		end
		slot = (cur - 1) % LEAVES;
		leaf_data[slot] = v;
		return rtks_pkg::ST_OK;
	endfunction

	// Work out the response to one request and update the shadow tree.
	function automatic answer_t predict_answer(logic [rtks_pkg::CMD_W-1:0] op, logic [63:0] k,
		logic [31:0] v);
		answer_t a;
		int slot;
		int cur;
		int holder;
		a = '{status: rtks_pkg::ST_NOTFOUND, found_value: '0, leaf_slot: '0};
		slot = 0;
		if (op == rtks_pkg::CMD_PUT) begin
			a.status = insert(k, v, slot);
		end else if ((op == rtks_pkg::CMD_GET || op == rtks_pkg::CMD_DEL)
			&& k <= capacity(depth)) begin
			cur = root;
			holder = -1;
			for (int h = depth; h >= 1 && cur != 0; h--) begin
				holder = child_index(cur, k, h);
				cur = children[holder];
			end
			if (cur != 0) begin
				slot = (cur - 1) % LEAVES;
				a.status = rtks_pkg::ST_OK;
				if (op == rtks_pkg::CMD_GET) begin
					a.found_value = leaf_data[slot];
				end else begin
					if (freed_count < LEAVES) begin
						freed_slots[freed_count] = slot;
						freed_count++;
					end
					if (holder >= 0)
						children[holder] = 0;
					else
						root = 0;
				end
			end
		end
		if (a.status == rtks_pkg::ST_OK)
			a.leaf_slot = rtks_pkg::SLOT_W'(slot);
		else
			a.found_value = '0;
		return a;
	endfunction

	// Compare responses first, then predict for a request taken on the same edge.
	always @(posedge clk or negedge arst_n) begin
		answer_t due;
		int      errs;
		if (!arst_n) begin
			depth       = 0;
			root        = 0;
			branch_fill = 0;
			leaf_fill   = 0;
			freed_count = 0;
			failures    <= 0;
			outstanding <= 0;
			answers_due.delete();
		end else begin
			errs = 0;
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					$error("response transaction with no request pending");
					errs++;
				end else begin
					due = answers_due.pop_front();
					if (rsp.status !== due.status) begin
						$error("status: expected %0d, actual %0d", due.status, rsp.status);
						errs++;
					end
					if (rsp.found_value !== due.found_value) begin
						$error("found_value: expected %h, actual %h", due.found_value,
							rsp.found_value);
						errs++;
					end
					if (rsp.leaf_slot !== due.leaf_slot) begin
						$error("leaf_slot: expected %0d, actual %0d", due.leaf_slot,
							rsp.leaf_slot);
						errs++;
					end
				end
			end
			if (errs != 0)
				failures <= failures + errs;
			if (req.valid && req.ready)
				answers_due.push_back(predict_answer(req.cmd, req.key, req.value));
			outstanding <= answers_due.size();
		end
	end

endmodule
`default_nettype wire

// ===== bench/radix_tree_key_store_core_tb.sv =====
// Top of the radix tree key store testbench: clock, reset, stimulus and verdict.
`default_nettype none
module radix_tree_key_store_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [rtks_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam int               IDLE_LIMIT  = 20000;
	localparam int               RANDOM_ITEMS = 1330;

	logic clk;
	logic arst_n;
	int   failures;
	int   outstanding;
	bit   calm;
	int   rsp_stall;
	int   quiet_cycles;
	int   sent;
	int   per_cmd [4];
	logic [63:0] used_keys [$];

	rtks_req_if req_ch ();
	rtks_rsp_if rsp_ch ();

	radix_tree_key_store_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	radix_tree_key_store_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// Clock with a 12 ns period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Response side back-pressure in random bursts, none once the run is calm.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall    <= 0;
		end else if (calm) begin
			rsp_ch.ready <= 1'b1;
		end else if (rsp_stall > 0) begin
			rsp_stall    <= rsp_stall - 1;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rsp_stall    <= $urandom_range(1, 11) - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n && !((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("radix_tree_key_store_core: mismatch");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	// Present one request, after an optional idle burst, and hold it until taken.
	task automatic send(logic [rtks_pkg::CMD_W-1:0] op, logic [63:0] k, logic [31:0] v);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= op;
		req_ch.key   <= k;
		req_ch.value <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		per_cmd[op]++;
		if (op == rtks_pkg::CMD_PUT && used_keys.size() < 512)
			used_keys.push_back(k);
	endtask

	// Keys mostly stay short so the branch pool lasts; some reuse earlier puts.
	function automatic logic [63:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return {$urandom, $urandom};
		if (r < 50 && used_keys.size() > 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		if (r < 60)
			return 64'($urandom) >> $urandom_range(0, 31);
		return 64'($urandom_range(0, 4095));
	endfunction

	function automatic logic [rtks_pkg::CMD_W-1:0] pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 42)
			return rtks_pkg::CMD_PUT;
		if (r < 75)
			return rtks_pkg::CMD_GET;
		if (r < 97)
			return rtks_pkg::CMD_DEL;
		return CMD_UNKNOWN;
	endfunction

	initial begin
		calm          = 1'b0;
		quiet_cycles  = 0;
		sent          = 0;
		per_cmd       = '{default: 0};
		req_ch.valid  = 1'b0;
		req_ch.cmd    = rtks_pkg::CMD_GET;
		req_ch.key    = '0;
		req_ch.value  = '0;
		arst_n        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tree, the single-leaf root, full-width keys, recycling.
		send(rtks_pkg::CMD_GET, 64'd0, 32'h0);
		send(rtks_pkg::CMD_DEL, 64'd0, 32'h0);
		send(rtks_pkg::CMD_PUT, 64'd0, 32'hFFFF_FFFF);
		send(rtks_pkg::CMD_PUT, 64'd0, 32'h1234_5678);
		send(rtks_pkg::CMD_GET, 64'd0, 32'h0);
		send(rtks_pkg::CMD_GET, 64'd5, 32'h0);
		send(rtks_pkg::CMD_DEL, 64'd5, 32'h0);
		send(rtks_pkg::CMD_PUT, '1, 32'hA5A5_5A5A);
		send(rtks_pkg::CMD_GET, '1, 32'h0);
		send(rtks_pkg::CMD_GET, 64'd0, 32'h0);
		send(rtks_pkg::CMD_GET, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0);
		send(rtks_pkg::CMD_DEL, '1, 32'h0);
		send(rtks_pkg::CMD_DEL, '1, 32'h0);
		send(CMD_UNKNOWN, 64'd0, 32'hFFFF_FFFF);
		send(rtks_pkg::CMD_PUT, 64'h10, 32'h0000_0001);
		send(rtks_pkg::CMD_PUT, 64'h8000_0000_0000_0000, 32'h0);
		send(rtks_pkg::CMD_GET, 64'h10, 32'h0);
		send(rtks_pkg::CMD_DEL, 64'd0, 32'h0);
		send(rtks_pkg::CMD_PUT, 64'd0, 32'hDEAD_BEEF);
		send(rtks_pkg::CMD_GET, 64'd0, 32'h0);
		send(rtks_pkg::CMD_PUT, 64'h0123_4567_89AB_CDEF, 32'h5555_AAAA);
		send(rtks_pkg::CMD_GET, 64'h0123_4567_89AB_CDEF, 32'h0);

		// Hold the sender off until every response has been checked.
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);

		// Random traffic; the last part runs without idling on either side.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - 150)
				calm = 1'b1;
			send(pick_cmd(), pick_key(), $urandom);
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);

		$display("Ran %0d requests: %0d get, %0d put, %0d delete, %0d unknown command.",
			sent, per_cmd[rtks_pkg::CMD_GET], per_cmd[rtks_pkg::CMD_PUT],
			per_cmd[rtks_pkg::CMD_DEL], per_cmd[CMD_UNKNOWN]);
		$display("Keys spanned the empty tree up to full 64-bit depth with pool exhaustion.");
		if (failures == 0)
			$display("radix_tree_key_store_core: match");
		else
			$display("radix_tree_key_store_core: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
